/* rtl/tgd_pkg.sv */
// ----------------------------------------------------------------------------
// tgd_pkg: shared types and constants for the touch gesture detector
// Phase codes, gesture codes, register map and register reset values.
// ----------------------------------------------------------------------------
package tgd_pkg;

	// Default widths of the input word fields
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_INIT_BASELINE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOUCH_PERCENT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PRESS     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAP_MAX       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_TAP    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECAL_IVL     = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECAL_ALPHA   = 3'd7;

	// Register widths
	localparam int PCT_BITS   = 7;
	localparam int MS_BITS    = 16;
	localparam int ALPHA_BITS = 9;

	// Register reset values
	localparam logic [15:0]           INIT_BASELINE_RST = 16'd65535;
	localparam logic [PCT_BITS-1:0]   TOUCH_PERCENT_RST = 7'd98;
	localparam logic [MS_BITS-1:0]    MIN_PRESS_RST     = 16'd50;
	localparam logic [MS_BITS-1:0]    TAP_MAX_RST       = 16'd500;
	localparam logic [MS_BITS-1:0]    DOUBLE_TAP_RST    = 16'd300;
	localparam logic [MS_BITS-1:0]    LONG_PRESS_RST    = 16'd800;
	localparam logic [MS_BITS-1:0]    RECAL_IVL_RST     = 16'd30000;
	localparam logic [ALPHA_BITS-1:0] RECAL_ALPHA_RST   = 9'd13;

	// Threshold divisor (percent) and unity weight of the moving average
	localparam int                    PCT_SCALE = 100;
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;
	localparam int                    ALPHA_SHIFT = 8;

	// Phase codes
	localparam int PH_BITS = 3;
	localparam logic [PH_BITS-1:0] PH_IDLE         = 3'd0;
	localparam logic [PH_BITS-1:0] PH_PRESSED      = 3'd1;
	localparam logic [PH_BITS-1:0] PH_WAIT_SECOND  = 3'd2;
	localparam logic [PH_BITS-1:0] PH_LONG_FIRED   = 3'd3;
	localparam logic [PH_BITS-1:0] PH_WAIT_RELEASE = 3'd4;

	// Gesture codes
	typedef enum logic [1:0] {
		GEST_TAP    = 2'd0,
		GEST_DOUBLE = 2'd1,
		GEST_LONG   = 2'd2
	} gesture_t;

endpackage

/* rtl/touch_gesture_detector.sv */
// ----------------------------------------------------------------------------
// touch_gesture_detector: single-pad tap / double tap / long press detector
// Polls pass through an input register, then combinational compare and
// phase logic updates the state and loads the result register.
// ----------------------------------------------------------------------------
// Takes one poll word (sample, time_ms) per clock unless in_stall is high; a
// gesture word, if the poll causes one, goes from the input register through
// the phase logic into the result register, which then presents it.
// Throughput is one poll per cycle, set by the phase and baseline update on
// the held state; the input stalls only while the result register is full
// and its consumer stalls. The pad is touched when 100*(sample+1) <=
// baseline*percent, which equals sample < floor(baseline*percent/100).
// Writing initial_baseline also reloads the running baseline. The user must
// write configuration only while no poll is in flight; the block itself does
// not enforce this. cfg_ready is always high.
module touch_gesture_detector #(
	parameter int SAMPLE_BITS = tgd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = tgd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// poll channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [SAMPLE_BITS-1:0]           sample,
	input  logic [TIME_BITS-1:0]             time_ms,
	// gesture channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       gesture,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tgd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tgd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int TB  = TIME_BITS;
	localparam int CMPW = SB + 8;    // holds 100*(sample+1) and baseline*percent
	localparam int MAW  = SB + 11;   // moving average accumulator, signed

	// Configuration registers
	logic [tgd_pkg::PCT_BITS-1:0]      pct_q;
	logic [tgd_pkg::MS_BITS-1:0]       min_press_q;
	logic [tgd_pkg::MS_BITS-1:0]       tap_max_q;
	logic [tgd_pkg::MS_BITS-1:0]       double_tap_q;
	logic [tgd_pkg::MS_BITS-1:0]       long_press_q;
	logic [tgd_pkg::MS_BITS-1:0]       recal_ivl_q;
	logic [tgd_pkg::ALPHA_BITS-1:0]    alpha_q;

	// Gesture state
	logic [tgd_pkg::PH_BITS-1:0]       phase_q;
	logic [TB-1:0]                     press_start_q;
	logic [TB-1:0]                     release_stamp_q;
	logic [TB-1:0]                     last_recal_q;
	logic [SB-1:0]                     baseline_q;

	// Input stage
	logic                              valid_s1;
	logic [SB-1:0]                     sample_s1;
	logic [TB-1:0]                     time_s1;

	// Result register
	logic                              out_valid_q;
	tgd_pkg::gesture_t                 gesture_q;

	// Step logic
	logic                              can_proc;
	logic                              proc;
	logic [CMPW-1:0]                   lhs;
	logic [CMPW-1:0]                   rhs;
	logic                              touched;
	logic [TB-1:0]                     held;
	logic [TB-1:0]                     gap;
	logic [TB-1:0]                     idle_time;
	logic [tgd_pkg::ALPHA_BITS-1:0]    alpha_sat;
	logic signed [MAW-1:0]             diff;
	logic signed [MAW-1:0]             acc;
	logic [SB-1:0]                     baseline_avg;
	logic [tgd_pkg::PH_BITS-1:0]       phase_nxt;
	logic                              set_press;
	logic                              set_release;
	logic                              do_recal;
	logic                              emit;
	tgd_pkg::gesture_t                 gest_nxt;

	// Handshakes: the input stage moves on whenever the result slot is free or draining
	assign can_proc  = !out_valid_q || !out_stall;
	assign proc      = valid_s1 && can_proc;
	assign in_stall  = valid_s1 && !can_proc;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	// Touch test without a divider
	assign lhs     = CMPW'(sample_s1) * CMPW'(tgd_pkg::PCT_SCALE) + CMPW'(tgd_pkg::PCT_SCALE);
	assign rhs     = CMPW'(baseline_q) * CMPW'(pct_q);
	assign touched = lhs <= rhs;

	// Elapsed times, modulo 2^TB
	assign held      = time_s1 - press_start_q;
	assign gap       = time_s1 - release_stamp_q;
	assign idle_time = time_s1 - last_recal_q;

	// Moving average: b + a*(x-b)/256, one multiply
	assign alpha_sat    = (alpha_q > tgd_pkg::ALPHA_ONE) ? tgd_pkg::ALPHA_ONE : alpha_q;
	assign diff         = $signed(MAW'(sample_s1)) - $signed(MAW'(baseline_q));
	assign acc          = $signed(MAW'(baseline_q) << tgd_pkg::ALPHA_SHIFT)
	                    + diff * $signed(MAW'(alpha_sat));
	assign baseline_avg = acc[SB+tgd_pkg::ALPHA_SHIFT-1:tgd_pkg::ALPHA_SHIFT];

	// Phase logic
	always_comb begin
		phase_nxt   = phase_q;
		set_press   = 1'b0;
		set_release = 1'b0;
		do_recal    = 1'b0;
		emit        = 1'b0;
		gest_nxt    = tgd_pkg::GEST_TAP;
		case (phase_q)
			tgd_pkg::PH_PRESSED: begin
				if (!touched) begin
					if (held < TB'(min_press_q)) begin
						phase_nxt = tgd_pkg::PH_IDLE;
					end else if (held < TB'(tap_max_q)) begin
						phase_nxt   = tgd_pkg::PH_WAIT_SECOND;
						set_release = 1'b1;
					end else begin
						phase_nxt = tgd_pkg::PH_IDLE;
					end
				end else if (held >= TB'(long_press_q)) begin
					emit      = 1'b1;
					gest_nxt  = tgd_pkg::GEST_LONG;
					phase_nxt = tgd_pkg::PH_LONG_FIRED;
				end
			end
			tgd_pkg::PH_WAIT_SECOND: begin
				if (touched) begin
					emit      = 1'b1;
					gest_nxt  = tgd_pkg::GEST_DOUBLE;
					phase_nxt = tgd_pkg::PH_WAIT_RELEASE;
				end else if (gap >= TB'(double_tap_q)) begin
					emit      = 1'b1;
					gest_nxt  = tgd_pkg::GEST_TAP;
					phase_nxt = tgd_pkg::PH_IDLE;
				end
			end
			tgd_pkg::PH_LONG_FIRED, tgd_pkg::PH_WAIT_RELEASE: begin
				if (!touched) begin
					phase_nxt = tgd_pkg::PH_IDLE;
				end
			end
			default: begin
				// idle, and any unused code
				if (touched) begin
					phase_nxt = tgd_pkg::PH_PRESSED;
					set_press = 1'b1;
				end else begin
					phase_nxt = tgd_pkg::PH_IDLE;
					do_recal  = idle_time >= TB'(recal_ivl_q);
				end
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
			time_s1   <= time_ms;
		end
	end

	// Configuration registers, gesture state and baseline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q           <= tgd_pkg::TOUCH_PERCENT_RST;
			min_press_q     <= tgd_pkg::MIN_PRESS_RST;
			tap_max_q       <= tgd_pkg::TAP_MAX_RST;
			double_tap_q    <= tgd_pkg::DOUBLE_TAP_RST;
			long_press_q    <= tgd_pkg::LONG_PRESS_RST;
			recal_ivl_q     <= tgd_pkg::RECAL_IVL_RST;
			alpha_q         <= tgd_pkg::RECAL_ALPHA_RST;
			phase_q         <= tgd_pkg::PH_IDLE;
			press_start_q   <= '0;
			release_stamp_q <= '0;
			last_recal_q    <= '0;
			baseline_q      <= SB'(tgd_pkg::INIT_BASELINE_RST);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					// initial_baseline only reloads the running baseline
					tgd_pkg::REG_INIT_BASELINE: baseline_q <= SB'(cfg_data);
					tgd_pkg::REG_TOUCH_PERCENT: pct_q        <= cfg_data[tgd_pkg::PCT_BITS-1:0];
					tgd_pkg::REG_MIN_PRESS:     min_press_q  <= cfg_data;
					tgd_pkg::REG_TAP_MAX:       tap_max_q    <= cfg_data;
					tgd_pkg::REG_DOUBLE_TAP:    double_tap_q <= cfg_data;
					tgd_pkg::REG_LONG_PRESS:    long_press_q <= cfg_data;
					tgd_pkg::REG_RECAL_IVL:     recal_ivl_q  <= cfg_data;
					tgd_pkg::REG_RECAL_ALPHA:   alpha_q      <= cfg_data[tgd_pkg::ALPHA_BITS-1:0];
					default: ;
				endcase
			end
			if (proc) begin
				phase_q <= phase_nxt;
				if (set_press) begin
					press_start_q <= time_s1;
				end
				if (set_release) begin
					release_stamp_q <= time_s1;
				end
				if (do_recal) begin
					baseline_q   <= baseline_avg;
					last_recal_q <= time_s1;
				end
			end
		end
	end

	// Result register: a processed poll always finds the slot free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			gesture_q <= gest_nxt;
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the touch gesture detector
// Polls with planned press timings go in through a random-gap driver, gesture
// words come back through a monitor that stalls at random. A behavioral pad
// model scores every accepted poll and the monitor checks the words in order.
// The run goes through several register settings, low and high extremes too.
// ----------------------------------------------------------------------------
module tb_top;
	import tgd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 4000;

	typedef struct {
		logic [PH_BITS-1:0]         phase;
		logic [TIME_BITS_DEF-1:0]   press_t;
		logic [TIME_BITS_DEF-1:0]   release_t;
		logic [TIME_BITS_DEF-1:0]   recal_t;
		logic [SAMPLE_BITS_DEF-1:0] baseline;
	} pad_state_t;

	typedef struct {
		logic [15:0]           init_base;
		logic [PCT_BITS-1:0]   pct;
		logic [MS_BITS-1:0]    min_ms;
		logic [MS_BITS-1:0]    tap_ms;
		logic [MS_BITS-1:0]    dbl_ms;
		logic [MS_BITS-1:0]    long_ms;
		logic [MS_BITS-1:0]    recal_ms;
		logic [ALPHA_BITS-1:0] alpha;
	} pad_cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS_DEF-1:0] sample;
		logic [TIME_BITS_DEF-1:0]   stamp;
	} poll_t;

	// DUT connections
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [SAMPLE_BITS_DEF-1:0] sample = '0;
	logic [TIME_BITS_DEF-1:0]   time_ms = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [1:0]                 gesture;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

	// model state: pad_cfg shared, plan_st for stimulus, live_st for scoring
	pad_cfg_t   pad_cfg;
	pad_state_t plan_st;
	pad_state_t live_st;
	poll_t      poll_q[$];
	gesture_t   gesture_q[$];
	logic [TIME_BITS_DEF-1:0] now_ms = '0;
	int         polls_queued = 0;
	int         err_cnt = 0;

	// idling knobs, written by the stimulus process only
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;

	// driver / monitor locals
	int       send_gap = 0;
	bit       poll_took;
	bit       live_fired;
	gesture_t live_gest;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       stall_left = 0;
	int       idle_cycles = 0;

	touch_gesture_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gesture   (gesture),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// touch threshold of the current baseline
	function automatic logic [31:0] touch_level(pad_state_t st);
		return (32'(st.baseline) * 32'(pad_cfg.pct)) / PCT_SCALE;
	endfunction

	// one poll through the pad phase machine
	function automatic void advance_pad(inout pad_state_t st, input logic [15:0] x,
			input logic [31:0] t, output bit fired, output gesture_t g);
		logic [31:0]           held;
		logic [ALPHA_BITS-1:0] a;
		logic [31:0]           mix;
		bit                    touched;
		touched = 32'(x) < touch_level(st);
		fired = 1'b0;
		g = GEST_TAP;
		case (st.phase)
			PH_PRESSED: begin
				held = t - st.press_t;
				if (!touched) begin
					if (held < pad_cfg.min_ms)
						st.phase = PH_IDLE;
					else if (held < pad_cfg.tap_ms) begin
						st.phase = PH_WAIT_SECOND;
						st.release_t = t;
					end else
						st.phase = PH_IDLE;
				end else if (held >= pad_cfg.long_ms) begin
					fired = 1'b1;
					g = GEST_LONG;
					st.phase = PH_LONG_FIRED;
				end
			end
			PH_WAIT_SECOND: begin
				if (touched) begin
					fired = 1'b1;
					g = GEST_DOUBLE;
					st.phase = PH_WAIT_RELEASE;
				end else if (t - st.release_t >= pad_cfg.dbl_ms) begin
					fired = 1'b1;
					g = GEST_TAP;
					st.phase = PH_IDLE;
				end
			end
			PH_LONG_FIRED, PH_WAIT_RELEASE: begin
				if (!touched)
					st.phase = PH_IDLE;
			end
			default: begin
				if (touched) begin
					st.phase = PH_PRESSED;
					st.press_t = t;
				end else begin
					st.phase = PH_IDLE;
					if (t - st.recal_t >= pad_cfg.recal_ms) begin
						// moving average, alpha saturates at unity
						a = (pad_cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : pad_cfg.alpha;
						mix = (32'(ALPHA_ONE - a) * 32'(st.baseline) + 32'(a) * 32'(x))
							>> ALPHA_SHIFT;
						st.baseline = mix[15:0];
						st.recal_t = t;
					end
				end
			end
		endcase
	endfunction

	function automatic int pick(int lo, int hi);
		return (hi <= lo) ? lo : lo + int'($urandom_range(0, hi - lo));
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns MISMATCH %s", $realtime, msg);
		err_cnt++;
	endtask

	// queue one poll and advance the planning copy of the pad
	task automatic emit_raw(logic [15:0] s, int dt);
		bit       f;
		gesture_t g;
		now_ms += 32'(dt);
		advance_pad(plan_st, s, now_ms, f, g);
		poll_q.push_back('{sample: s, stamp: now_ms});
		polls_queued++;
	endtask

	// queue a touched or untouched poll with a random sample on that side
	task automatic emit(bit want_touch, int dt);
		logic [31:0] lvl;
		logic [15:0] s;
		lvl = touch_level(plan_st);
		s = 16'($urandom());
		if (want_touch && lvl != 0)
			s = 16'($urandom_range(0, (lvl > 32'h10000) ? 32'hFFFF : lvl - 1));
		else if (!want_touch && lvl <= 32'hFFFF)
			s = 16'($urandom_range(lvl, 32'hFFFF));
		emit_raw(s, dt);
	endtask

	// press held for dur ms with n polls inside, last poll touched or not
	task automatic press(int dur, int n, bit end_touch);
		int rem;
		int step;
		emit(1'b1, pick(1, 40));
		rem = dur;
		repeat (n) begin
			step = pick(0, rem);
			emit(1'b1, step);
			rem -= step;
		end
		emit(end_touch, rem);
	endtask

	task automatic double_tap();
		press(pick(pad_cfg.min_ms, int'(pad_cfg.tap_ms) - 1), pick(0, 1), 1'b0);
		emit(1'b1, pick(0, int'(pad_cfg.dbl_ms) - 1));
		emit(1'b0, pick(1, 40));
	endtask

	// one random gesture-shaped sequence, or noise
	task automatic random_gesture();
		int r;
		r = pick(0, 99);
		if (r < 22) begin
			press(pick(pad_cfg.min_ms, int'(pad_cfg.tap_ms) - 1), pick(0, 2), 1'b0);
			emit(1'b0, pick(pad_cfg.dbl_ms, int'(pad_cfg.dbl_ms) + 50));
		end else if (r < 40)
			double_tap();
		else if (r < 55) begin
			press(pick(pad_cfg.long_ms, int'(pad_cfg.long_ms) + 200), pick(0, 2), 1'b1);
			if (pick(0, 1) == 1)
				emit(1'b1, pick(1, 100));
			emit(1'b0, pick(1, 50));
		end else if (r < 63)
			press(pick(0, int'(pad_cfg.min_ms) - 1), 0, 1'b0);
		else if (r < 71)
			press(pick(pad_cfg.tap_ms, int'(pad_cfg.long_ms) - 1), pick(0, 2), 1'b0);
		else if (r < 78)
			emit(1'b0, pick(pad_cfg.recal_ms, int'(pad_cfg.recal_ms) + 500));
		else if (r < 88)
			emit_raw(16'($urandom()), pick(0, 3000));
		else if (r < 94) begin
			now_ms = $urandom();
			emit_raw(16'($urandom()), 0);
		end else
			emit_raw(pick(0, 1) == 1 ? 16'hFFFF : 16'h0000, pick(0, 200));
	endtask

	task automatic fill_polls(int n);
		int goal;
		goal = polls_queued + n;
		while (polls_queued < goal)
			random_gesture();
	endtask

	// sender pause: all polls taken, all gestures back, pipeline settled
	task automatic drain();
		while (poll_q.size() != 0 || gesture_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write every register, then load the model (block is idle here)
	task automatic program_regs(pad_cfg_t c);
		logic [15:0] d;
		for (int i = 0; i < 8; i++) begin
			case (CFG_IDX_BITS'(i))
				REG_INIT_BASELINE: d = c.init_base;
				REG_TOUCH_PERCENT: d = 16'(c.pct);
				REG_MIN_PRESS:     d = c.min_ms;
				REG_TAP_MAX:       d = c.tap_ms;
				REG_DOUBLE_TAP:    d = c.dbl_ms;
				REG_LONG_PRESS:    d = c.long_ms;
				REG_RECAL_IVL:     d = c.recal_ms;
				default:           d = 16'(c.alpha);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data <= d;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		pad_cfg = c;
		plan_st.baseline = c.init_base;
		live_st.baseline = c.init_base;
	endtask

	// poll driver: scores each accepted word, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			poll_took = in_valid && !in_stall;
			if (poll_took) begin
				advance_pad(live_st, sample, time_ms, live_fired, live_gest);
				if (live_fired)
					gesture_q.push_back(live_gest);
				void'(poll_q.pop_front());
			end
			// a stalled word stays as it is
			if (!in_valid || poll_took) begin
				if (poll_took && send_gap_pct != 0 && pick(1, 100) <= send_gap_pct)
					send_gap = pick(1, 14);
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (poll_q.size() != 0) begin
					in_valid <= 1'b1;
					sample <= poll_q[0].sample;
					time_ms <= poll_q[0].stamp;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// gesture monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				if (gesture_q.size() == 0)
					report_mismatch($sformatf("unexpected gesture word %0d", gesture));
				else begin
					if (gesture !== gesture_q[0])
						report_mismatch($sformatf("gesture expected %s got %0d",
							gesture_q[0].name(), gesture));
					void'(gesture_q.pop_front());
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_pct != 0 && pick(1, 100) <= stall_pct) begin
				stall_left = pick(1, 14) - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		pad_cfg_t c;
		pad_cfg_t rst_cfg;
		rst_cfg = '{INIT_BASELINE_RST, TOUCH_PERCENT_RST, MIN_PRESS_RST, TAP_MAX_RST,
			DOUBLE_TAP_RST, LONG_PRESS_RST, RECAL_IVL_RST, RECAL_ALPHA_RST};
		pad_cfg = rst_cfg;
		live_st = '{PH_IDLE, '0, '0, '0, INIT_BASELINE_RST};
		plan_st = live_st;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extremes, each gesture, drift, time wrap
		send_gap_pct = 20;
		stall_pct = 8;
		emit_raw(16'hFFFF, 5);
		emit_raw(16'h0000, 5);
		emit_raw(16'hFFFF, 100);
		emit_raw(16'hFFFF, 400);
		emit_raw(16'h0000, 10);
		emit_raw(16'hFFFF, 60);
		emit_raw(16'h0000, 100);
		emit_raw(16'hFFFF, 20);
		emit_raw(16'h0000, 10);
		emit_raw(16'h1234, 300);
		emit_raw(16'h0000, 600);
		emit_raw(16'h0000, 100);
		emit_raw(16'hFFFF, 10);
		emit_raw(16'h0000, 10);
		emit_raw(16'hFFFF, 20);
		emit_raw(16'h0000, 10);
		emit_raw(16'hFFFF, 600);
		emit_raw(16'hFBF4, 30000);
		now_ms = 32'hFFFF_FFC0;
		emit_raw(16'h0000, 0);
		emit_raw(16'hFFFF, 100);
		emit_raw(16'hFFFF, 300);
		fill_polls(60);
		drain();

		// low extremes: zero baseline and percent, zero times, no idling
		send_gap_pct = 0;
		stall_pct = 0;
		program_regs('{16'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 9'd0});
		fill_polls(20);
		drain();

		// high extremes: percent above 100, longest times but zero min press, alpha above unity
		send_gap_pct = 30;
		stall_pct = 15;
		program_regs('{16'd40000, 7'd127, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			9'd511});
		fill_polls(60);
		drain();

		// full-weight drift on every idle poll, short windows
		program_regs('{16'd50000, 7'd100, 16'd10, 16'd200, 16'd100, 16'd400, 16'd0,
			ALPHA_ONE});
		fill_polls(60);
		drain();

		// receiver holds off while double taps keep coming in
		c = rst_cfg;
		c.recal_ms = 16'd1000;
		program_regs(c);
		hold_req++;
		repeat (25) double_tap();
		drain();

		// random settings
		send_gap_pct = 15;
		stall_pct = 10;
		repeat (4) begin
			c.init_base = 16'($urandom());
			c.pct = 7'($urandom_range(0, 127));
			c.min_ms = 16'($urandom_range(0, 200));
			c.tap_ms = 16'($urandom_range(0, 800));
			c.dbl_ms = 16'($urandom_range(0, 500));
			c.long_ms = 16'($urandom_range(0, 1500));
			c.recal_ms = 16'($urandom_range(0, 5000));
			c.alpha = 9'($urandom_range(0, 511));
			program_regs(c);
			fill_polls(40);
			drain();
		end

		// closing stretch at full rate on reset settings
		send_gap_pct = 0;
		stall_pct = 0;
		program_regs(rst_cfg);
		fill_polls(60);
		drain();

		if (err_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/tgd_pkg.sv
rtl/touch_gesture_detector.sv
test/tb_top.sv
